// ----- hdl/npd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_pkg
// shared types and constants of the nearest point symbol demapper
// ----------------------------------------------------------------------------
package npd_pkg;

    localparam int COORD_BITS = 16;
    localparam int LABEL_BITS = 6;
    localparam int INDEX_BITS = 6;
    localparam int DIST_BITS  = 2 * COORD_BITS + 2;
    localparam int BPS_BITS   = 3;
    localparam int LAST_BITS  = 8;

    localparam logic [BPS_BITS-1:0] BPS_RESET = 3'd2;
    localparam logic [BPS_BITS-1:0] BPS_MIN   = 3'd1;
    localparam logic [BPS_BITS-1:0] BPS_MAX   = 3'd6;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_DEMAP = 1'b1
    } t_op;

    typedef struct packed {
        t_op                           op;
        logic [INDEX_BITS-1:0]         entry_index;
        logic signed [COORD_BITS-1:0]  coord_i;
        logic signed [COORD_BITS-1:0]  coord_q;
        logic [LABEL_BITS-1:0]         entry_label;
    } t_in_item;

    typedef struct packed {
        logic [LABEL_BITS-1:0] decided_label;
        logic [INDEX_BITS-1:0] nearest_index;
        logic [DIST_BITS-1:0]  distance_sq;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        t_op                           op;
        logic [INDEX_BITS-1:0]         entry_index;
        logic signed [COORD_BITS-1:0]  coord_i;
        logic signed [COORD_BITS-1:0]  coord_q;
        logic [LABEL_BITS-1:0]         entry_label;
        logic [BPS_BITS-1:0]           bps;
        logic [LAST_BITS-1:0]          last_idx;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [LABEL_BITS-1:0] label_mask(input logic [BPS_BITS-1:0] m);
        logic [LABEL_BITS:0] ones;
        ones = (LABEL_BITS+1)'(1) << m;
        ones = ones - (LABEL_BITS+1)'(1);
        return ones[LABEL_BITS-1:0];
    endfunction

endpackage

// ----- hdl/nearest_point_symbol_demapper_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_symbol_demapper_top
// hard-decision minimum-distance constellation demapper
// ----------------------------------------------------------------------------
// A transaction is taken at a clock edge with start high and busy low. A load
// transaction writes one table entry (I/Q point and label) and gives no
// result; a demap transaction searches the first 2^bits_per_symbol entries
// (capped at MAX_POINTS) and gives one result, strobed for exactly one cycle
// on o_result_valid; the receiver cannot stall, so it must take every result
// in that cycle. Results come out in transaction order. The search time of a
// demap is set by the single read port of the point table, which yields one
// point per cycle; a load is written to the table when the search takes it
// from the queue, which waits while a demap is searching. A two-entry command
// queue sits in front of the search, so busy rises only when two
// transactions are waiting. Table entries have no reset: load every point in
// use before demapping. Write bits_per_symbol only while no transaction is
// outstanding.
// ----------------------------------------------------------------------------
module nearest_point_symbol_demapper_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: bits_per_symbol
    input  logic                         i_cfg_we,
    input  logic [npd_pkg::BPS_BITS-1:0] i_cfg_wdata,
    // command side
    input  logic                         start,
    input  npd_pkg::t_in_item            i_item,
    output logic                         busy,
    // result side
    output logic                         o_result_valid,
    output npd_pkg::t_out_item           o_result
);
    import npd_pkg::*;

    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // front: config register, saturation of bits_per_symbol, point count
    npd_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .i_item      (i_item),
        .i_q_status  (q_status),
        .busy        (busy),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // queue decouples transaction intake from the search
    npd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // back: point table, squared distance pipeline, running minimum
    npd_search #(
        .MAX_POINTS (MAX_POINTS)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ----- hdl/npd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_front
// holds the bits_per_symbol register and turns transactions into commands
// ----------------------------------------------------------------------------
module npd_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [npd_pkg::BPS_BITS-1:0] i_cfg_wdata,
    input  logic                         start,
    input  npd_pkg::t_in_item            i_item,
    input  npd_pkg::t_q_status           i_q_status,
    output logic                         busy,
    output logic                         o_push,
    output npd_pkg::t_cmd                o_cmd
);
    import npd_pkg::*;

    logic [BPS_BITS-1:0] r_bps;
    logic [BPS_BITS-1:0] m_sat;
    logic [8:0]          cnt;
    logic [8:0]          last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps <= BPS_RESET;
        end else if (i_cfg_we) begin
            r_bps <= i_cfg_wdata;
        end
    end

    // saturate to the meaningful range, cap the count at table depth
    always_comb begin
        m_sat = r_bps;
        if (r_bps < BPS_MIN) begin
            m_sat = BPS_MIN;
        end else if (r_bps > BPS_MAX) begin
            m_sat = BPS_MAX;
        end
        cnt  = 9'd1 << m_sat;
        last = (cnt > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) - 9'd1 : cnt - 9'd1;
    end

    assign busy   = i_q_status.full;
    assign o_push = start && !i_q_status.full;

    always_comb begin
        o_cmd.op          = i_item.op;
        o_cmd.entry_index = i_item.entry_index;
        o_cmd.coord_i     = i_item.coord_i;
        o_cmd.coord_q     = i_item.coord_q;
        o_cmd.entry_label = i_item.entry_label;
        o_cmd.bps         = m_sat;
        o_cmd.last_idx    = last[LAST_BITS-1:0];
    end

endmodule

// ----- hdl/npd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module npd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  npd_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output npd_pkg::t_cmd      o_cmd,
    output npd_pkg::t_q_status o_status
);
    import npd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= 2'd2)) else $error("queue count out of range");

endmodule

// ----- hdl/npd_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_search
// point table and sequential nearest point search, one point per cycle
// ----------------------------------------------------------------------------
module npd_search #(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  npd_pkg::t_cmd      i_cmd,
    input  npd_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_result_valid,
    output npd_pkg::t_out_item o_result
);
    import npd_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);

    typedef struct packed {
        logic [LABEL_BITS-1:0]        label;
        logic signed [COORD_BITS-1:0] ci;
        logic signed [COORD_BITS-1:0] cq;
    } t_point;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_point r_mem [MAX_POINTS];
    t_point r_rd_word;

    t_state                  r_state;
    logic                    r_issue_on;
    logic [IW-1:0]           r_rd_idx;
    logic [IW-1:0]           r_last;
    logic [BPS_BITS-1:0]     r_bps;
    logic signed [COORD_BITS-1:0] r_si;
    logic signed [COORD_BITS-1:0] r_sq;
    // stage 1: table word
    logic                    r_v1;
    logic                    r_last1;
    logic [IW-1:0]           r_idx1;
    // stage 2: squares
    logic                    r_v2;
    logic                    r_last2;
    logic [IW-1:0]           r_idx2;
    logic [LABEL_BITS-1:0]   r_lab2;
    logic [2*COORD_BITS:0]   r_sqr_i;
    logic [2*COORD_BITS:0]   r_sqr_q;
    // running best
    logic [DIST_BITS-1:0]    r_best_d;
    logic [IW-1:0]           r_best_k;
    logic [LABEL_BITS-1:0]   r_best_lab;

    logic                          load_ok;
    logic signed [COORD_BITS:0]    di;
    logic signed [COORD_BITS:0]    dq;
    logic signed [2*COORD_BITS+1:0] pi;
    logic signed [2*COORD_BITS+1:0] pq;
    logic [DIST_BITS-1:0]          sum;
    logic                          take;
    logic [DIST_BITS-1:0]          nx_d;
    logic [IW-1:0]                 nx_k;
    logic [LABEL_BITS-1:0]         nx_lab;

    assign o_pop   = (r_state == S_IDLE) && !i_q_status.empty;
    assign load_ok = 9'(i_cmd.entry_index) < 9'(MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == OP_LOAD && load_ok) begin
            r_mem[IW'(i_cmd.entry_index)] <= {i_cmd.entry_label, i_cmd.coord_i,
                                              i_cmd.coord_q};
        end
        if (r_issue_on) begin
            r_rd_word <= r_mem[r_rd_idx];
        end
    end

    always_comb begin
        di     = {r_rd_word.ci[COORD_BITS-1], r_rd_word.ci} - {r_si[COORD_BITS-1], r_si};
        dq     = {r_rd_word.cq[COORD_BITS-1], r_rd_word.cq} - {r_sq[COORD_BITS-1], r_sq};
        pi     = di * di;
        pq     = dq * dq;
        sum    = DIST_BITS'(r_sqr_i) + DIST_BITS'(r_sqr_q);
        // strict compare, index zero always seeds the search
        take   = (r_idx2 == '0) || (sum < r_best_d);
        nx_d   = take ? sum    : r_best_d;
        nx_k   = take ? r_idx2 : r_best_k;
        nx_lab = take ? r_lab2 : r_best_lab;
    end

    always_ff @(posedge i_clk) begin
        r_sqr_i <= pi[2*COORD_BITS:0];
        r_sqr_q <= pq[2*COORD_BITS:0];
        r_lab2  <= r_rd_word.label;
        r_idx2  <= r_idx1;
        r_idx1  <= r_rd_idx;
        r_last1 <= (r_rd_idx == r_last);
        r_last2 <= r_last1;
        if (r_v2) begin
            r_best_d   <= nx_d;
            r_best_k   <= nx_k;
            r_best_lab <= nx_lab;
        end
        if (o_pop) begin
            r_si   <= i_cmd.coord_i;
            r_sq   <= i_cmd.coord_q;
            r_bps  <= i_cmd.bps;
            r_last <= i_cmd.last_idx[IW-1:0];
        end
        if (r_v2 && r_last2) begin
            o_result.decided_label <= nx_lab & label_mask(r_bps);
            o_result.nearest_index <= INDEX_BITS'(nx_k);
            o_result.distance_sq   <= nx_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_issue_on     <= 1'b0;
            r_rd_idx       <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            r_v1           <= r_issue_on;
            r_v2           <= r_v1;
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.op == OP_DEMAP) begin
                        r_state    <= S_SCAN;
                        r_issue_on <= 1'b1;
                        r_rd_idx   <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_issue_on) begin
                        if (r_rd_idx == r_last) begin
                            r_issue_on <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + IW'(1);
                        end
                    end
                    if (r_v2 && r_last2) begin
                        o_result_valid <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("back-to-back result strobe");
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_last2) |=> o_result_valid) else $error("search end without result");
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue_on |-> (r_state == S_SCAN && r_rd_idx <= r_last))
        else $error("table read past last point");
    a_no_pop_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_pop) else $error("command taken during search");

endmodule

// ----- test/nearest_point_symbol_demapper_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_symbol_demapper_top_test
// self-checking bench for the minimum-distance constellation demapper
// ----------------------------------------------------------------------------
// A queue of pending transactions is filled phase by phase and drained by a
// clocked driver that inserts random idle cycles. Each accepted transaction
// runs through a table model of the demapper that predicts the decision of
// every demap; a clocked monitor compares each strobed result field by field
// with the oldest prediction. bits_per_symbol is rewritten between phases,
// once the block has gone quiet, sweeping every code including both
// saturating ones.
// ----------------------------------------------------------------------------
module nearest_point_symbol_demapper_top_test;

    import npd_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 100;      // longest demap searches all 64 points
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 175;      // per phase, nine phases
    localparam longint unsigned DIST_ALL_ONES = (64'd1 << DIST_BITS) - 1;

    // ------------------------------------------------------------------------
    // clock, reset and the signals of the block
    // ------------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [BPS_BITS-1:0] cfg_wdata = '0;
    logic                start     = 1'b0;
    t_in_item            item      = '0;
    logic                busy;
    logic                result_valid;
    t_out_item           result;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nearest_point_symbol_demapper_top #(
        .MAX_POINTS(TABLE_DEPTH)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .start         (start),
        .i_item        (item),
        .busy          (busy),
        .o_result_valid(result_valid),
        .o_result      (result)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_in_item  pending_items[$];     // transactions waiting for the driver
    t_out_item decision_q[$];        // predicted decisions, oldest first

    // table model, updated as transactions are accepted
    shortint             tbl_i[TABLE_DEPTH];
    shortint             tbl_q[TABLE_DEPTH];
    logic [LABEL_BITS-1:0] tbl_label[TABLE_DEPTH];
    logic [BPS_BITS-1:0] model_bps = BPS_RESET;

    // what the stimulus has already queued, so demaps only read loaded entries
    shortint             plan_i[TABLE_DEPTH];
    shortint             plan_q[TABLE_DEPTH];
    bit                  plan_ok[TABLE_DEPTH];
    logic [BPS_BITS-1:0] plan_bps = BPS_RESET;

    int unsigned gap_pct     = 0;    // chance of an idle cycle on the sender
    int unsigned n_queued    = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_loads     = 0;
    int unsigned n_demaps    = 0;
    int unsigned n_checked   = 0;
    int unsigned n_cfg       = 0;
    int unsigned errors      = 0;
    int unsigned cycles      = 0;

    // number of table entries searched; codes 0 and 7 saturate to 1 and 6
    function automatic int points_in_use(logic [BPS_BITS-1:0] bps);
        int m;
        m = bps;
        if (m < BPS_MIN) m = BPS_MIN;
        if (m > BPS_MAX) m = BPS_MAX;
        return 1 << m;
    endfunction

    // ------------------------------------------------------------------------
    // table model: loads update the table, demaps predict one decision
    // ------------------------------------------------------------------------
    function automatic void predict_decision(t_in_item t);
        int        used, k, best_k;
        longint    si, sq, di, dq, d, best_d;
        t_out_item r;
        if (t.op == OP_LOAD) begin
            tbl_i[t.entry_index]     = shortint'(t.coord_i);
            tbl_q[t.entry_index]     = shortint'(t.coord_q);
            tbl_label[t.entry_index] = t.entry_label;
            n_loads++;
            return;
        end
        used   = points_in_use(model_bps);
        si     = longint'(shortint'(t.coord_i));
        sq     = longint'(shortint'(t.coord_q));
        best_k = 0;
        best_d = 0;
        for (k = 0; k < used; k++) begin
            di = longint'(tbl_i[k]) - si;
            dq = longint'(tbl_q[k]) - sq;
            d  = di * di + dq * dq;
            // strict compare: on a tie the lower index stays
            if (k == 0 || d < best_d) begin
                best_d = d;
                best_k = k;
            end
        end
        if (best_d > longint'(DIST_ALL_ONES)) best_d = longint'(DIST_ALL_ONES);
        r.decided_label = tbl_label[best_k] & LABEL_BITS'(used - 1);
        r.nearest_index = INDEX_BITS'(best_k);
        r.distance_sq   = DIST_BITS'(best_d);
        decision_q.insert(decision_q.size(), r);
        n_demaps++;
    endfunction

    // ------------------------------------------------------------------------
    // driver: holds a transaction until busy lets it through, then takes the
    // next one from the queue unless a random idle cycle is drawn
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive
        logic     next_start;
        t_in_item next_item;
        next_start = start;
        next_item  = item;
        if (!rst_n) begin
            next_start = 1'b0;
        end else begin
            if (start && !busy) begin
                predict_decision(item);
                n_accepted++;
                next_start = 1'b0;
            end
            if (!next_start && pending_items.size() != 0 &&
                $urandom_range(99) >= gap_pct) begin
                next_item  = pending_items.pop_front();
                next_start = 1'b1;
            end
        end
        start <= next_start;
        item  <= next_item;
    end

    // ------------------------------------------------------------------------
    // monitor: every strobed result must match the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t ERROR: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin : watch
        t_out_item want;
        if (rst_n && result_valid) begin
            if (decision_q.size() == 0) begin
                $display("%0t ERROR: unexpected result, expected none actual %h",
                         $time, result);
                errors++;
            end else begin
                want = decision_q.pop_front();
                check_field("decided_label", want.decided_label, result.decided_label);
                check_field("nearest_index", want.nearest_index, result.nearest_index);
                check_field("distance_sq", want.distance_sq, result.distance_sq);
                n_checked++;
            end
        end
    end

    // run guard
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t ERROR: timeout after %0d cycles", $time, cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic shortint any_coord();
        return shortint'($urandom_range(65535));
    endfunction

    function automatic shortint extreme_coord();
        case ($urandom_range(4))
            0:       return -16'sd32768;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    // a point disturbed by noise of random magnitude, clipped to the range
    function automatic shortint nudge(shortint c);
        int span, v;
        span = 1 << $urandom_range(14);
        v = int'(c) + int'($urandom_range(2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return shortint'(v);
    endfunction

    function automatic void push_load(int idx, shortint ci, shortint cq, int lab);
        t_in_item t;
        t.op          = OP_LOAD;
        t.entry_index = INDEX_BITS'(idx);
        t.coord_i     = ci;
        t.coord_q     = cq;
        t.entry_label = LABEL_BITS'(lab);
        plan_i[idx]   = ci;
        plan_q[idx]   = cq;
        plan_ok[idx]  = 1'b1;
        pending_items.insert(pending_items.size(), t);
        n_queued++;
    endfunction

    // index and label of a demap are don't-care, so they toggle at random
    function automatic void push_demap(shortint ci, shortint cq);
        t_in_item t;
        t.op          = OP_DEMAP;
        t.entry_index = INDEX_BITS'($urandom_range(63));
        t.coord_i     = ci;
        t.coord_q     = cq;
        t.entry_label = LABEL_BITS'($urandom_range(63));
        pending_items.insert(pending_items.size(), t);
        n_queued++;
    endfunction

    // every entry a demap can read gets loaded first
    function automatic void load_missing();
        int k;
        for (k = 0; k < points_in_use(plan_bps); k++) begin
            if (!plan_ok[k]) push_load(k, any_coord(), any_coord(), $urandom_range(63));
        end
    endfunction

    function automatic void random_items(int n);
        int      j, used, roll, idx, src;
        shortint ci, cq;
        used = points_in_use(plan_bps);
        for (j = 0; j < n; j++) begin
            roll = $urandom_range(99);
            src  = $urandom_range(used - 1);
            if (roll < 15) begin
                // reshape the constellation, mostly inside the points in use
                idx  = ($urandom_range(99) < 60) ? $urandom_range(used - 1)
                                                 : $urandom_range(63);
                roll = $urandom_range(99);
                if (roll < 10) begin
                    ci = plan_i[src];       // duplicate point makes a tie
                    cq = plan_q[src];
                end else if (roll < 40) begin
                    ci = extreme_coord();
                    cq = extreme_coord();
                end else begin
                    ci = any_coord();
                    cq = any_coord();
                end
                push_load(idx, ci, cq, $urandom_range(63));
            end else begin
                if (roll < 58) begin
                    ci = nudge(plan_i[src]);  // noisy sample near a point
                    cq = nudge(plan_q[src]);
                end else if (roll < 85) begin
                    ci = any_coord();
                    cq = any_coord();
                end else begin
                    ci = extreme_coord();
                    cq = extreme_coord();
                end
                push_demap(ci, cq);
            end
        end
    endfunction

    // wait until every queued transaction is taken and every result is back,
    // then let a load or demap still in the pipe finish
    task automatic settle();
        int waited;
        while (n_accepted != n_queued) @(posedge clk);
        waited = 0;
        while (decision_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (decision_q.size() != 0) begin
            $display("%0t ERROR: %0d results expected, none arrived",
                     $time, decision_q.size());
            errors++;
            decision_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bps(logic [BPS_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_bps = value;
        plan_bps  = value;
        n_cfg++;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [BPS_BITS-1:0] bps_plan[8];
        int                  phase;
        bps_plan = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd4, 3'd5, 3'd2};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct = 6;

        // directed, four points at the reset setting
        // corners of the full coordinate range, labels cover all bit values
        push_load(0, -16'sd32768, -16'sd32768, 6'h00);
        push_load(1, 16'sd32767, -16'sd32768, 6'h2A);
        push_load(2, -16'sd32768, 16'sd32767, 6'h15);
        push_load(3, 16'sd32767, 16'sd32767, 6'h3F);
        push_demap(16'sd32767, 16'sd32767);      // exact hit, label masked
        push_demap(-16'sd32768, -16'sd32768);
        push_demap(16'sd32767, -16'sd32768);
        push_demap(-16'sd32768, 16'sd32767);
        push_demap(16'sd0, 16'sd0);
        push_demap(-16'sd1, -16'sd1);
        // diamond around the origin: ties of two and of all four points
        push_load(0, 16'sd100, 16'sd0, 6'd3);
        push_load(1, -16'sd100, 16'sd0, 6'd2);
        push_load(2, 16'sd0, 16'sd100, 6'd1);
        push_load(3, 16'sd0, -16'sd100, 6'd0);
        push_demap(16'sd0, 16'sd0);              // four-way tie, lowest index
        push_demap(16'sd0, 16'sd1);
        push_demap(-16'sd1, 16'sd0);
        push_demap(16'sd70, 16'sd70);            // tie between entries 0 and 2
        // all points on one corner, sample on the opposite: largest distance
        push_load(0, 16'sd32767, 16'sd32767, 6'd9);
        push_load(1, 16'sd32767, 16'sd32767, 6'd8);
        push_load(2, 16'sd32767, 16'sd32767, 6'd7);
        push_load(3, 16'sd32767, 16'sd32767, 6'd6);
        push_demap(-16'sd32768, -16'sd32768);
        random_items(RANDOM_ITEMS);
        settle();

        // one phase per setting; the sender idle rate changes after the second and fifth
        for (phase = 0; phase < 8; phase++) begin
            gap_pct = (phase < 2) ? 6 : (phase < 5) ? 83 : 0;
            write_bps(bps_plan[phase]);
            load_missing();
            random_items(RANDOM_ITEMS);
            settle();
        end

        $display("covered %0d demap and %0d load transactions, %0d results checked",
                 n_demaps, n_loads, n_checked);
        $display("bits_per_symbol written %0d times, codes 0 to 7, sender gaps 6/83/0 pct",
                 n_cfg);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
